>>> hdl/acf_pkg.sv
package acf_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int AXES             = 3;
  localparam int CW               = 36;   // CORDIC x/y width, covers gain growth
  localparam int SQ_W             = 48;
  localparam int SQ_ITERS         = 24;
  localparam int CNT_W            = 5;
  localparam logic [23:0] GYRO_K  = 24'd11199533;

  localparam logic [1:0] REG_BLEND   = 2'd0;
  localparam logic [1:0] REG_DEFSTEP = 2'd1;
  localparam logic [1:0] REG_MAXSTEP = 2'd2;

  localparam logic [15:0] BLEND_RST   = 16'd64225;
  localparam logic [16:0] DEFSTEP_RST = 17'd10000;
  localparam logic [19:0] MAXSTEP_RST = 20'd100000;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SQ_Y, OP_SQ_Z, OP_SQRT, OP_CRD_INIT, OP_CRD_STEP,
    OP_CRD_DONE, OP_G_DT, OP_G_K, OP_BL_ACC, OP_BL_PRED, OP_YAW, OP_OUT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [CNT_W-1:0] idx;
    logic [1:0]       axis;
  } cmd_t;

  typedef struct packed {
    logic [15:0] blend_weight;
    logic [16:0] default_step_us;
    logic [19:0] max_step_us;
  } cfg_t;

  function automatic logic [31:0] atan_ent(input logic [CNT_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/acf_if.sv
interface acf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  logic [19:0]        elapsed_us;
  modport source(output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                 elapsed_us, input ready);
  modport sink(input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
               elapsed_us, output ready);
endinterface

interface acf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  modport source(output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink(input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

>>> hdl/acf_regs.sv
module acf_regs import acf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_BLEND:   cfg_nxt.blend_weight    = pwdata[15:0];
        REG_DEFSTEP: cfg_nxt.default_step_us = pwdata[16:0];
        REG_MAXSTEP: cfg_nxt.max_step_us     = pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blend_weight    <= BLEND_RST;
      cfg_r.default_step_us <= DEFSTEP_RST;
      cfg_r.max_step_us     <= MAXSTEP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BLEND:   prdata = {16'b0, cfg_r.blend_weight};
      REG_DEFSTEP: prdata = {15'b0, cfg_r.default_step_us};
      REG_MAXSTEP: prdata = {12'b0, cfg_r.max_step_us};
      default:     prdata = 32'b0;
    endcase
  end

  assign pready = 1'b1;
  assign cfg    = cfg_r;

endmodule

>>> hdl/acf_ctrl.sv
module acf_ctrl import acf_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  localparam int NSTEP = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

  typedef enum logic [12:0] {
    S_IDLE  = 13'h0001,
    S_SQY   = 13'h0002,
    S_SQZ   = 13'h0004,
    S_SQRT  = 13'h0008,
    S_CINIT = 13'h0010,
    S_CSTEP = 13'h0020,
    S_CDONE = 13'h0040,
    S_GDT   = 13'h0080,
    S_GK    = 13'h0100,
    S_BACC  = 13'h0200,
    S_BPRED = 13'h0400,
    S_YAW   = 13'h0800,
    S_WOUT  = 13'h1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       axis_r, axis_nxt;
  logic             ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    axis_nxt  = axis_r;
    ov_nxt    = ov_r && !out_ready;
    cmd.op    = OP_NONE;
    cmd.idx   = cnt_r;
    cmd.axis  = axis_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_SQY;
        end
      end
      S_SQY: begin
        cmd.op    = OP_SQ_Y;
        state_nxt = S_SQZ;
      end
      S_SQZ: begin
        cmd.op    = OP_SQ_Z;
        cnt_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op  = OP_SQRT;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQ_ITERS - 1)) begin
          cnt_nxt   = '0;
          axis_nxt  = 2'd0;
          state_nxt = S_CINIT;
        end
      end
      S_CINIT: begin
        cmd.op    = OP_CRD_INIT;
        cnt_nxt   = '0;
        state_nxt = S_CSTEP;
      end
      S_CSTEP: begin
        cmd.op  = OP_CRD_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NSTEP - 1)) begin
          state_nxt = S_CDONE;
        end
      end
      S_CDONE: begin
        cmd.op = OP_CRD_DONE;
        if (axis_r == 2'd0) begin
          axis_nxt  = 2'd1;
          state_nxt = S_CINIT;
        end else begin
          axis_nxt  = 2'd0;
          state_nxt = S_GDT;
        end
      end
      S_GDT: begin
        cmd.op    = OP_G_DT;
        state_nxt = S_GK;
      end
      S_GK: begin
        cmd.op    = OP_G_K;
        state_nxt = (axis_r == 2'd2) ? S_YAW : S_BACC;
      end
      S_BACC: begin
        cmd.op    = OP_BL_ACC;
        state_nxt = S_BPRED;
      end
      S_BPRED: begin
        cmd.op    = OP_BL_PRED;
        axis_nxt  = axis_r + 1'b1;
        state_nxt = S_GDT;
      end
      S_YAW: begin
        cmd.op    = OP_YAW;
        state_nxt = S_WOUT;
      end
      S_WOUT: begin
        // previous result must be gone before the output register reloads
        if (!ov_r || out_ready) begin
          cmd.op    = OP_OUT;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      axis_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      axis_r  <= axis_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a beat while busy");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT) |-> (!ov_r || out_ready))
    else $error("result overwritten before taken");
  a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CSTEP) |-> (cnt_r < CNT_W'(NSTEP)))
    else $error("cordic step count overrun");
  a_axis_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BACC || state_r == S_BPRED) |-> (axis_r < 2'd2))
    else $error("blend on yaw axis");

endmodule

>>> hdl/acf_datapath.sv
module acf_datapath import acf_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  cfg_t               cfg,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_x,
  input  logic signed [15:0] gyro_y,
  input  logic signed [15:0] gyro_z,
  input  logic [19:0]        elapsed_us,
  output logic signed [15:0] roll_angle,
  output logic signed [15:0] pitch_angle,
  output logic signed [15:0] yaw_angle
);

  localparam int SH = 32 - ANGLE_BITS;
  localparam logic [31:0] RND_HALF = 32'd1 << (SH - 1);
  localparam logic [31:0] RND_MASK = ~((32'd1 << SH) - 32'd1);

  logic signed [15:0] ax_r, ay_r, az_r;
  logic signed [15:0] g_r [AXES];
  logic [19:0]        dt_r;
  logic [SQ_W-1:0]    sqv_r, sqr_r, sqb_r;
  logic signed [CW-1:0] cx_r, cy_r;
  logic [31:0]        cz_r;
  logic               czero_r;
  logic [31:0]        ref_r [2];
  logic [31:0]        ang_r [AXES];
  logic [36:0]        m1_r;
  logic signed [37:0] delta_r;
  logic signed [56:0] bl_r;
  logic [15:0]        out_r [AXES];

  // shared multiplier
  logic signed [39:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [64:0] prod;

  logic signed [15:0] g_sel;
  logic signed [16:0] g_ext;
  logic [16:0]        g_mag;
  logic signed [38:0] pred;
  logic [31:0]        ref_sel;

  assign g_sel   = g_r[cmd.axis];
  assign g_ext   = {g_sel[15], g_sel};
  assign g_mag   = g_ext[16] ? 17'(-g_ext) : 17'(g_ext);
  assign pred    = {{7{ang_r[cmd.axis][31]}}, ang_r[cmd.axis]} + {delta_r[37], delta_r};
  assign ref_sel = ref_r[cmd.axis[0]];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SQ_Y: begin
        mul_a = {{24{ay_r[15]}}, ay_r};
        mul_b = {{9{ay_r[15]}}, ay_r};
      end
      OP_SQ_Z: begin
        mul_a = {{24{az_r[15]}}, az_r};
        mul_b = {{9{az_r[15]}}, az_r};
      end
      OP_G_DT: begin
        mul_a = {23'b0, g_mag};
        mul_b = {5'b0, dt_r};
      end
      OP_G_K: begin
        mul_a = {3'b0, m1_r};
        mul_b = {1'b0, GYRO_K};
      end
      OP_BL_ACC: begin
        mul_a = {{8{ref_sel[31]}}, ref_sel};
        mul_b = {8'b0, 17'h10000 - {1'b0, cfg.blend_weight}};
      end
      OP_BL_PRED: begin
        mul_a = {pred[38], pred};
        mul_b = {9'b0, cfg.blend_weight};
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // elapsed time select and clamp
  logic [19:0] dt_sel, dt_lim;
  assign dt_sel = (elapsed_us == 20'd0) ? {3'b0, cfg.default_step_us} : elapsed_us;
  assign dt_lim = (dt_sel > cfg.max_step_us) ? cfg.max_step_us : dt_sel;

  // square root step
  logic [SQ_W-1:0] sq_t;
  assign sq_t = sqr_r + sqb_r;

  // CORDIC start vectors
  logic signed [CW-1:0] x0, y0;
  always_comb begin
    if (cmd.axis == 2'd0) begin
      x0 = {{(CW-32){az_r[15]}}, az_r, 16'b0};
      y0 = {{(CW-32){ay_r[15]}}, ay_r, 16'b0};
    end else begin
      x0 = {{(CW-32){1'b0}}, sqr_r[23:0], 8'b0};
      y0 = -{{(CW-32){ax_r[15]}}, ax_r, 16'b0};
    end
  end

  logic signed [CW-1:0] dx, dy;
  logic [31:0]          at;
  assign dx = cy_r >>> cmd.idx;
  assign dy = cx_r >>> cmd.idx;
  assign at = atan_ent(cmd.idx);

  logic [64:0]        g_rnd;
  logic [37:0]        d_mag;
  logic signed [56:0] bl_sum;
  assign g_rnd  = prod + 65'sd8388608;
  assign d_mag  = g_rnd[61:24];
  assign bl_sum = bl_r + prod[56:0] + 57'sd32768;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        ax_r   <= accel_x;
        ay_r   <= accel_y;
        az_r   <= accel_z;
        g_r[0] <= gyro_x;
        g_r[1] <= gyro_y;
        g_r[2] <= gyro_z;
        dt_r   <= dt_lim;
      end
      OP_SQ_Y: sqv_r <= prod[SQ_W-1:0];
      OP_SQ_Z: begin
        sqv_r <= (sqv_r + prod[SQ_W-1:0]) << 16;
        sqr_r <= '0;
        sqb_r <= SQ_W'(1) << (SQ_W - 2);
      end
      OP_SQRT: begin
        if (sqv_r >= sq_t) begin
          sqv_r <= sqv_r - sq_t;
          sqr_r <= (sqr_r >> 1) + sqb_r;
        end else begin
          sqr_r <= sqr_r >> 1;
        end
        sqb_r <= sqb_r >> 2;
      end
      OP_CRD_INIT: begin
        czero_r <= (x0 == '0) && (y0 == '0);
        if (x0 < 0) begin
          cx_r <= -x0;
          cy_r <= -y0;
          cz_r <= 32'h80000000;
        end else begin
          cx_r <= x0;
          cy_r <= y0;
          cz_r <= 32'h0;
        end
      end
      OP_CRD_STEP: begin
        if (cy_r > 0) begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          cz_r <= cz_r + at;
        end else begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          cz_r <= cz_r - at;
        end
      end
      OP_CRD_DONE: ref_r[cmd.axis[0]] <= czero_r ? 32'h0 : ((cz_r + RND_HALF) & RND_MASK);
      OP_G_DT:     m1_r <= prod[36:0];
      OP_G_K:      delta_r <= g_sel[15] ? -$signed(d_mag) : $signed(d_mag);
      OP_BL_ACC:   bl_r <= prod[56:0];
      OP_OUT: begin
        out_r[0] <= 16'((ang_r[0] + 32'h8000) >> 16);
        out_r[1] <= 16'((ang_r[1] + 32'h8000) >> 16);
        out_r[2] <= 16'((ang_r[2] + 32'h8000) >> 16);
      end
      default: ;
    endcase
  end

  // filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_r[0] <= '0;
      ang_r[1] <= '0;
      ang_r[2] <= '0;
    end else if (cmd.op == OP_BL_PRED) begin
      ang_r[cmd.axis] <= bl_sum[47:16];
    end else if (cmd.op == OP_YAW) begin
      ang_r[2] <= ang_r[2] + delta_r[31:0];
    end
  end

  assign roll_angle  = out_r[0];
  assign pitch_angle = out_r[1];
  assign yaw_angle   = out_r[2];

endmodule

>>> hdl/attitude_complementary_filter_core.sv
// From input beat to result valid: squaring of y and z, the square-root iterations,
// two CORDIC runs (roll, then pitch), each an init, its steps (CORDIC_STEPS, capped
// at 24) and a done, gyro/blend math on a single shared multiplier, then the output load.
// One item in flight at a time; the next input is accepted only in the idle state
// after the result is loaded, and the load waits while an earlier result is not taken.
// Reset (rst_n, synchronous, active low) zeroes the angles and loads register defaults.
module attitude_complementary_filter_core import acf_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  acf_in_if.sink      in_ch,
  acf_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t cfg;
  cmd_t cmd;

  acf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  acf_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  acf_datapath #(.ANGLE_BITS(ANGLE_BITS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg         (cfg),
    .accel_x     (in_ch.accel_x),
    .accel_y     (in_ch.accel_y),
    .accel_z     (in_ch.accel_z),
    .gyro_x      (in_ch.gyro_x),
    .gyro_y      (in_ch.gyro_y),
    .gyro_z      (in_ch.gyro_z),
    .elapsed_us  (in_ch.elapsed_us),
    .roll_angle  (out_ch.roll_angle),
    .pitch_angle (out_ch.pitch_angle),
    .yaw_angle   (out_ch.yaw_angle)
  );

endmodule
